[src/frd_pkg.sv]
package frd_pkg;

    // Fixed sizes of the datapath.
    localparam int MAX_VIEW_SIZE = 4096;
    localparam int VIEW_W        = 13;
    localparam int PIX_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;
    localparam int COEF_BITS     = 16;
    localparam int DIR_W         = 16;

    // Quotient and square root results are Q30 magnitudes on 31 bits.
    localparam int QUO_W         = 31;
    localparam int REM_W         = 62;

    // CORDIC datapath.
    localparam int CORDIC_STEPS  = 28;
    localparam int CORDIC_W      = 34;
    localparam int TRIG_W        = 32;
    localparam int LOC_W         = 26;

    localparam int PSI_K_W       = 21;
    localparam int FK_W          = VIEW_W + PSI_K_W;
    localparam int RFK_W         = QUO_W + FK_W;
    localparam int PSI_W         = 32;

    localparam logic [PSI_K_W-1:0]         PSI_K       = 21'd1171271;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic [PSI_W-1:0]           PI_Q28      = 32'd843314857;
    localparam logic [PSI_W-1:0]           HALF_PI_Q28 = 32'd421657428;
    localparam logic [QUO_W-1:0]           Q30_ONE     = 31'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_WIDTH    = 3'd0,
        REG_VIEW_HEIGHT   = 3'd1,
        REG_FIELD_OF_VIEW = 3'd2,
        REG_ROT_ROW_A     = 3'd3,
        REG_ROT_ROW_B     = 3'd4,
        REG_ROT_ROW_C     = 3'd5
    } cfg_reg_t;

    // Sideband that travels next to the normalizing dividers.
    typedef struct packed {
        logic valid;
        logic in_circle;
        logic neg_u;
        logic neg_v;
    } norm_side_t;

    // Sideband that travels next to the square root.
    typedef struct packed {
        logic             valid;
        logic             in_circle;
        logic             neg_u;
        logic             neg_v;
        logic [QUO_W-1:0] mag_u;
        logic [QUO_W-1:0] mag_v;
    } sqrt_side_t;

    // Sideband that travels next to the ratio dividers.
    typedef struct packed {
        logic             valid;
        logic             in_circle;
        logic             neg_u;
        logic             neg_v;
        logic             rzero;
        logic [QUO_W-1:0] radius;
    } ratio_side_t;

    // Sideband that travels next to the CORDIC.
    typedef struct packed {
        logic                     valid;
        logic                     in_circle;
        logic                     neg_cos;
        logic signed [TRIG_W-1:0] cos_a;
        logic signed [TRIG_W-1:0] sin_a;
    } cordic_side_t;

    // Arctangent of 2^-i in Q28 radians.
    function automatic logic signed [CORDIC_W-1:0] atan_q28(input int i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            0:       a = 34'sd210828714;
            1:       a = 34'sd124459457;
            2:       a = 34'sd65760959;
            3:       a = 34'sd33381290;
            4:       a = 34'sd16755422;
            5:       a = 34'sd8385879;
            6:       a = 34'sd4193963;
            7:       a = 34'sd2097109;
            8:       a = 34'sd1048571;
            9:       a = 34'sd524287;
            default: a = 34'sd1 <<< (28 - i);
        endcase
        return a;
    endfunction

endpackage

[src/frd_front.sv]
module frd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [frd_pkg::PIX_W-1:0]         column,
    input  logic [frd_pkg::PIX_W-1:0]         row,
    input  logic [frd_pkg::VIEW_W-1:0]        view_w,
    input  logic [frd_pkg::VIEW_W-1:0]        view_h,
    output frd_pkg::norm_side_t               side,
    output logic [frd_pkg::REM_W-1:0]         num_u,
    output logic [frd_pkg::REM_W-1:0]         num_v,
    output logic [frd_pkg::QUO_W-1:0]         den_u,
    output logic [frd_pkg::QUO_W-1:0]         den_v
);

    // Stage 0: signed offsets from the view center, doubled.
    logic signed [13:0] dx_next, dy_next, dx_reg, dy_reg;
    logic               zero_reg, v0_reg;

    assign dx_next = $signed({1'b0, column, 1'b0}) - $signed({1'b0, view_w});
    assign dy_next = $signed({1'b0, row, 1'b0}) - $signed({1'b0, view_h});

    // Stage 1: squares and magnitudes.
    logic signed [27:0] dx_sq, dy_sq;
    logic [25:0]        w_sq, h_sq;
    logic [13:0]        dx_abs, dy_abs;
    logic [26:0]        dx2_reg, dy2_reg;
    logic [24:0]        w2_reg, h2_reg;
    logic [12:0]        ax1_reg, ay1_reg;
    logic               sx1_reg, sy1_reg, zero1_reg, v1_reg;

    assign dx_sq  = dx_reg * dx_reg;
    assign dy_sq  = dy_reg * dy_reg;
    assign w_sq   = view_w * view_w;
    assign h_sq   = view_h * view_h;
    assign dx_abs = dx_reg[13] ? 14'(-dx_reg) : 14'(dx_reg);
    assign dy_abs = dy_reg[13] ? 14'(-dy_reg) : 14'(dy_reg);

    // Stage 2: cross products for the circle test.
    logic [51:0] ex_next, ey_next, wh_next;
    logic [51:0] ex_reg, ey_reg, wh_reg;
    logic [12:0] ax2_reg, ay2_reg;
    logic        sx2_reg, sy2_reg, zero2_reg, v2_reg;

    assign ex_next = dx2_reg * h2_reg;
    assign ey_next = dy2_reg * w2_reg;
    assign wh_next = 52'(w2_reg * h2_reg);

    // Stage 3: circle test and divider numerators.
    logic [52:0] dist_sum;
    logic        inside_next;

    assign dist_sum    = {1'b0, ex_reg} + {1'b0, ey_reg};
    assign inside_next = !zero2_reg && (dist_sum <= {1'b0, wh_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            side       <= '0;
        end
        else if (en)
        begin
            v0_reg         <= in_valid;
            v1_reg         <= v0_reg;
            v2_reg         <= v1_reg;
            side.valid     <= v2_reg;
            side.in_circle <= inside_next;
            side.neg_u     <= sx2_reg;
            side.neg_v     <= sy2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            zero_reg  <= (view_w == '0) || (view_h == '0);

            dx2_reg   <= dx_sq[26:0];
            dy2_reg   <= dy_sq[26:0];
            w2_reg    <= w_sq[24:0];
            h2_reg    <= h_sq[24:0];
            ax1_reg   <= dx_abs[12:0];
            ay1_reg   <= dy_abs[12:0];
            sx1_reg   <= dx_reg[13];
            sy1_reg   <= dy_reg[13];
            zero1_reg <= zero_reg;

            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            wh_reg    <= wh_next;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            zero2_reg <= zero1_reg;

            num_u     <= {19'b0, ax2_reg, 30'b0} + {50'b0, view_w[12:1]};
            num_v     <= {19'b0, ay2_reg, 30'b0} + {50'b0, view_h[12:1]};
            den_u     <= {18'b0, view_w};
            den_v     <= {18'b0, view_h};
        end
    end

endmodule

[src/frd_divider.sv]
module frd_divider (
    input  logic                      clk,
    input  logic                      en,
    input  logic [frd_pkg::REM_W-1:0] num,
    input  logic [frd_pkg::QUO_W-1:0] den,
    output logic [frd_pkg::QUO_W-1:0] quo
);

    // Restoring divider, one quotient bit per stage, most significant first.
    localparam int N = frd_pkg::QUO_W;
    localparam int W = frd_pkg::REM_W;

    logic [W-1:0] rem_reg  [N];
    logic [N-1:0] den_reg  [N];
    logic [N-1:0] quo_reg  [N];
    logic [W-1:0] rem_in   [N];
    logic [N-1:0] den_in   [N];
    logic [N-1:0] quo_in   [N];
    logic [W-1:0] rem_next [N];
    logic [N-1:0] quo_next [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int SH = N - 1 - k;
        logic [W-1:0] trial;
        logic         take;

        if (k == 0)
        begin : g_first
            assign rem_in[k] = num;
            assign den_in[k] = den;
            assign quo_in[k] = '0;
        end
        else
        begin : g_rest
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign quo_in[k] = quo_reg[k-1];
        end

        assign trial       = {{(W-N){1'b0}}, den_in[k]} << SH;
        assign take        = (rem_in[k] >= trial);
        assign rem_next[k] = take ? (rem_in[k] - trial) : rem_in[k];
        assign quo_next[k] = quo_in[k] | ({{(N-1){1'b0}}, take} << SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[N-1];

endmodule

[src/frd_sqrt.sv]
module frd_sqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [frd_pkg::REM_W-1:0] radicand,
    output logic [frd_pkg::QUO_W-1:0] root
);

    // Digit-by-digit integer square root, one result bit per stage.
    localparam int N  = frd_pkg::QUO_W;
    localparam int W  = frd_pkg::REM_W;
    localparam int WT = W + 1;

    logic [W-1:0] rem_reg   [N];
    logic [N-1:0] root_reg  [N];
    logic [W-1:0] rem_in    [N];
    logic [N-1:0] root_in   [N];
    logic [W-1:0] rem_next  [N];
    logic [N-1:0] root_next [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;
        logic [WT-1:0] trial;
        logic [WT-1:0] rem_ext;
        logic [WT-1:0] diff;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_in[k]  = radicand;
            assign root_in[k] = '0;
        end
        else
        begin : g_rest
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial        = ({{(WT-N){1'b0}}, root_in[k]} << (B + 1))
                            + ({{(WT-1){1'b0}}, 1'b1} << (2 * B));
        assign rem_ext      = {1'b0, rem_in[k]};
        assign take         = (rem_ext >= trial);
        assign diff         = rem_ext - trial;
        assign rem_next[k]  = take ? diff[W-1:0] : rem_in[k];
        assign root_next[k] = root_in[k] | ({{(N-1){1'b0}}, take} << B);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

[src/frd_cordic.sv]
module frd_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [frd_pkg::CORDIC_W-1:0] angle,
    output logic signed [frd_pkg::CORDIC_W-1:0] cos_out,
    output logic signed [frd_pkg::CORDIC_W-1:0] sin_out
);

    // Rotation-mode CORDIC, one micro-rotation per stage.
    localparam int N = frd_pkg::CORDIC_STEPS;
    localparam int W = frd_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg  [N];
    logic signed [W-1:0] y_reg  [N];
    logic signed [W-1:0] z_reg  [N];
    logic signed [W-1:0] x_in   [N];
    logic signed [W-1:0] y_in   [N];
    logic signed [W-1:0] z_in   [N];
    logic signed [W-1:0] x_next [N];
    logic signed [W-1:0] y_next [N];
    logic signed [W-1:0] z_next [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [W-1:0] ATAN = frd_pkg::atan_q28(i);
        logic signed [W-1:0] xs, ys;

        if (i == 0)
        begin : g_first
            assign x_in[i] = frd_pkg::CORDIC_K;
            assign y_in[i] = '0;
            assign z_in[i] = angle;
        end
        else
        begin : g_rest
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
        end

        assign xs = x_in[i] >>> i;
        assign ys = y_in[i] >>> i;

        assign x_next[i] = z_in[i][W-1] ? (x_in[i] + ys) : (x_in[i] - ys);
        assign y_next[i] = z_in[i][W-1] ? (y_in[i] - xs) : (y_in[i] + xs);
        assign z_next[i] = z_in[i][W-1] ? (z_in[i] + ATAN) : (z_in[i] - ATAN);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign cos_out = x_reg[N-1];
    assign sin_out = y_reg[N-1];

endmodule

[src/fisheye_ray_direction_top.sv]
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | column, row
// output  | out       | out_valid / out_ready| dir_x, dir_y, dir_z, defined
// config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item enters per clock unless the pipeline holds; items leave in order of acceptance.
// Most stages sit in the bit-per-stage dividers (31 stages, used twice),
// the bit-per-stage square root (31 stages) and the 28-stage CORDIC.
// Reset clears the valid bits and restores the configuration defaults.
// The whole pipeline advances together; it holds when the output item waits.
module fisheye_ray_direction_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [frd_pkg::PIX_W-1:0]           column,
    input  logic [frd_pkg::PIX_W-1:0]           row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [frd_pkg::DIR_W-1:0]    dir_x,
    output logic signed [frd_pkg::DIR_W-1:0]    dir_y,
    output logic signed [frd_pkg::DIR_W-1:0]    dir_z,
    output logic                                defined,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [frd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int QW = frd_pkg::QUO_W;
    localparam int CW = frd_pkg::CORDIC_W;
    localparam int TW = frd_pkg::TRIG_W;
    localparam int LW = frd_pkg::LOC_W;
    localparam int CB = frd_pkg::COEF_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes
    // are dropped.
    // ------------------------------------------------------------------
    logic [frd_pkg::VIEW_W-1:0]     width_reg, height_reg, fov_reg;
    logic [frd_pkg::CFG_DATA_W-1:0] rot_a_reg, rot_b_reg, rot_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            fov_reg    <= 13'd2880;
            rot_a_reg  <= 48'h4000_0000_0000;
            rot_b_reg  <= 48'h0000_4000_0000;
            rot_c_reg  <= 48'h0000_0000_4000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                frd_pkg::REG_VIEW_WIDTH:    width_reg  <= cfg_data[frd_pkg::VIEW_W-1:0];
                frd_pkg::REG_VIEW_HEIGHT:   height_reg <= cfg_data[frd_pkg::VIEW_W-1:0];
                frd_pkg::REG_FIELD_OF_VIEW: fov_reg    <= cfg_data[frd_pkg::VIEW_W-1:0];
                frd_pkg::REG_ROT_ROW_A:     rot_a_reg  <= cfg_data;
                frd_pkg::REG_ROT_ROW_B:     rot_b_reg  <= cfg_data;
                frd_pkg::REG_ROT_ROW_C:     rot_c_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // View sizes above the supported maximum are clamped.
    logic [frd_pkg::VIEW_W-1:0] view_w, view_h;

    assign view_w = (width_reg > 13'(frd_pkg::MAX_VIEW_SIZE))
                  ? 13'(frd_pkg::MAX_VIEW_SIZE) : width_reg;
    assign view_h = (height_reg > 13'(frd_pkg::MAX_VIEW_SIZE))
                  ? 13'(frd_pkg::MAX_VIEW_SIZE) : height_reg;

    // The field of view times the angle scale is a configuration product,
    // so it is kept in a register of its own ahead of the radius multiply.
    logic [frd_pkg::FK_W-1:0] fk_reg;

    always_ff @(posedge clk)
    begin
        fk_reg <= fov_reg * frd_pkg::PSI_K;
    end

    // ------------------------------------------------------------------
    // Global advance. The output register parts the two sides, so a new
    // item is taken whenever the output slot is empty or being drained.
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Front end: circle test and normalizer numerators (4 stages).
    // ------------------------------------------------------------------
    frd_pkg::norm_side_t          front_side;
    logic [frd_pkg::REM_W-1:0]    num_u, num_v;
    logic [QW-1:0]                den_u, den_v;

    frd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .column   (column),
        .row      (row),
        .view_w   (view_w),
        .view_h   (view_h),
        .side     (front_side),
        .num_u    (num_u),
        .num_v    (num_v),
        .den_u    (den_u),
        .den_v    (den_v)
    );

    // ------------------------------------------------------------------
    // Normalized coordinates |u|, |v| in Q30 (31 stages).
    // ------------------------------------------------------------------
    logic [QW-1:0]       mag_u, mag_v;
    frd_pkg::norm_side_t nd_reg [QW];

    frd_divider u_div_u (.clk(clk), .en(en), .num(num_u), .den(den_u), .quo(mag_u));
    frd_divider u_div_v (.clk(clk), .en(en), .num(num_v), .den(den_v), .quo(mag_v));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                nd_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            nd_reg[0] <= front_side;
            for (int k = 1; k < QW; k++)
            begin
                nd_reg[k] <= nd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Squares, then their sum (2 stages).
    // ------------------------------------------------------------------
    frd_pkg::sqrt_side_t       q1_side_reg, q2_side_reg;
    logic [frd_pkg::REM_W-1:0] usq_reg, vsq_reg, sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_side_reg <= '0;
            q2_side_reg <= '0;
        end
        else if (en)
        begin
            q1_side_reg.valid     <= nd_reg[QW-1].valid;
            q1_side_reg.in_circle <= nd_reg[QW-1].in_circle;
            q1_side_reg.neg_u     <= nd_reg[QW-1].neg_u;
            q1_side_reg.neg_v     <= nd_reg[QW-1].neg_v;
            q1_side_reg.mag_u     <= mag_u;
            q1_side_reg.mag_v     <= mag_v;
            q2_side_reg           <= q1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            usq_reg <= mag_u * mag_u;
            vsq_reg <= mag_v * mag_v;
            sum_reg <= usq_reg + vsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Radius r = floor(sqrt(u^2 + v^2)) in Q30 (31 stages).
    // ------------------------------------------------------------------
    logic [QW-1:0]       radius;
    frd_pkg::sqrt_side_t sq_reg [QW];

    frd_sqrt u_sqrt (.clk(clk), .en(en), .radicand(sum_reg), .root(radius));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                sq_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            sq_reg[0] <= q2_side_reg;
            for (int k = 1; k < QW; k++)
            begin
                sq_reg[k] <= sq_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Ratio numerators (1 stage), then u/r and v/r (31 stages).
    // ------------------------------------------------------------------
    frd_pkg::ratio_side_t      r0_side_reg;
    logic [frd_pkg::REM_W-1:0] rnum_u_reg, rnum_v_reg;
    logic [QW-1:0]             rden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_side_reg <= '0;
        end
        else if (en)
        begin
            r0_side_reg.valid     <= sq_reg[QW-1].valid;
            r0_side_reg.in_circle <= sq_reg[QW-1].in_circle;
            r0_side_reg.neg_u     <= sq_reg[QW-1].neg_u;
            r0_side_reg.neg_v     <= sq_reg[QW-1].neg_v;
            r0_side_reg.rzero     <= (radius == '0);
            r0_side_reg.radius    <= radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnum_u_reg <= {1'b0, sq_reg[QW-1].mag_u, 30'b0} + {32'b0, radius[QW-1:1]};
            rnum_v_reg <= {1'b0, sq_reg[QW-1].mag_v, 30'b0} + {32'b0, radius[QW-1:1]};
            rden_reg   <= radius;
        end
    end

    logic [QW-1:0]        rq_u, rq_v;
    frd_pkg::ratio_side_t rd_reg [QW];

    frd_divider u_div_cu (.clk(clk), .en(en), .num(rnum_u_reg), .den(rden_reg), .quo(rq_u));
    frd_divider u_div_sv (.clk(clk), .en(en), .num(rnum_v_reg), .den(rden_reg), .quo(rq_v));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rd_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            rd_reg[0] <= r0_side_reg;
            for (int k = 1; k < QW; k++)
            begin
                rd_reg[k] <= rd_reg[k-1];
            end
        end
    end

    // Signed, clamped direction cosines of the image-plane offset. At the
    // center pixel both are zero, which leaves the optical axis.
    logic [QW-1:0]        cu_mag, sv_mag;
    logic signed [TW-1:0] cos_next, sin_next;

    assign cu_mag   = (rq_u > frd_pkg::Q30_ONE) ? frd_pkg::Q30_ONE : rq_u;
    assign sv_mag   = (rq_v > frd_pkg::Q30_ONE) ? frd_pkg::Q30_ONE : rq_v;
    assign cos_next = rd_reg[QW-1].rzero ? '0
                    : (rd_reg[QW-1].neg_u ? -$signed({1'b0, cu_mag}) : $signed({1'b0, cu_mag}));
    assign sin_next = rd_reg[QW-1].rzero ? '0
                    : (rd_reg[QW-1].neg_v ? -$signed({1'b0, sv_mag}) : $signed({1'b0, sv_mag}));

    // ------------------------------------------------------------------
    // Angle psi = r * fov * k, then folded into [-pi/2, pi/2] (3 stages).
    // ------------------------------------------------------------------
    frd_pkg::cordic_side_t          p1_side_reg, p2_side_reg, p3_side_reg;
    logic [frd_pkg::RFK_W-1:0]      rfk_reg;
    logic [frd_pkg::RFK_W-1:0]      rfk_round;
    logic [frd_pkg::PSI_W-1:0]      psi_reg;
    logic                           fold;
    logic signed [CW-1:0]           z0_reg;

    assign rfk_round = rfk_reg + (65'd1 << 32);
    assign fold      = (psi_reg > frd_pkg::HALF_PI_Q28);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_side_reg <= '0;
            p2_side_reg <= '0;
            p3_side_reg <= '0;
        end
        else if (en)
        begin
            p1_side_reg.valid     <= rd_reg[QW-1].valid;
            p1_side_reg.in_circle <= rd_reg[QW-1].in_circle;
            p1_side_reg.neg_cos   <= 1'b0;
            p1_side_reg.cos_a     <= cos_next;
            p1_side_reg.sin_a     <= sin_next;
            p2_side_reg           <= p1_side_reg;
            p3_side_reg.valid     <= p2_side_reg.valid;
            p3_side_reg.in_circle <= p2_side_reg.in_circle;
            p3_side_reg.neg_cos   <= fold;
            p3_side_reg.cos_a     <= p2_side_reg.cos_a;
            p3_side_reg.sin_a     <= p2_side_reg.sin_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rfk_reg <= rd_reg[QW-1].radius * fk_reg;
            psi_reg <= rfk_round[64:33];
            z0_reg  <= fold ? $signed({2'b0, frd_pkg::PI_Q28}) - $signed({2'b0, psi_reg})
                            : $signed({2'b0, psi_reg});
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine of psi (28 stages).
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  cor_x, cor_y;
    frd_pkg::cordic_side_t cd_reg [frd_pkg::CORDIC_STEPS];

    frd_cordic u_cordic (
        .clk     (clk),
        .en      (en),
        .angle   (z0_reg),
        .cos_out (cor_x),
        .sin_out (cor_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < frd_pkg::CORDIC_STEPS; k++)
            begin
                cd_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            cd_reg[0] <= p3_side_reg;
            for (int k = 1; k < frd_pkg::CORDIC_STEPS; k++)
            begin
                cd_reg[k] <= cd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Local vector and matrix rotation (4 stages, the last one is the
    // output register).
    // ------------------------------------------------------------------
    frd_pkg::cordic_side_t last_side;
    logic signed [65:0]    pc_reg, ps_reg;
    logic signed [CW-1:0]  xm_reg;
    logic                  m1_valid_reg, m1_inside_reg;

    assign last_side = cd_reg[frd_pkg::CORDIC_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg <= cor_y * last_side.cos_a;
            ps_reg <= cor_y * last_side.sin_a;
            xm_reg <= last_side.neg_cos ? -cor_x : cor_x;
        end
    end

    // Q30 product rounding and the drop to Q24 collapse into one add.
    localparam logic signed [65:0] L_RND = (66'sd1 <<< 29) + (66'sd1 <<< 35);
    localparam logic signed [CW-1:0] X_RND = 34'sd32;

    logic signed [65:0]   lc_sum, ls_sum;
    logic signed [CW-1:0] lx_sum;
    logic signed [LW-1:0] loc_reg [3];
    logic                 m2_valid_reg, m2_inside_reg;

    assign lc_sum = pc_reg + L_RND;
    assign ls_sum = ps_reg + L_RND;
    assign lx_sum = xm_reg + X_RND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            loc_reg[0] <= $signed(lc_sum[61:36]);
            loc_reg[1] <= $signed(ls_sum[61:36]);
            loc_reg[2] <= $signed(lx_sum[31:6]);
        end
    end

    // Coefficient k of a packed matrix row, highest field first.
    function automatic logic signed [CB-1:0] coef(
        input logic [frd_pkg::CFG_DATA_W-1:0] rowv,
        input int k
    );
        logic [frd_pkg::CFG_DATA_W-1:0] sh;
        sh = rowv >> ((2 - k) * CB);
        return $signed(sh[CB-1:0]);
    endfunction

    logic [frd_pkg::CFG_DATA_W-1:0] rot_rows [3];
    logic signed [CB+LW-1:0]        prod_next [3][3];
    logic signed [CB+LW-1:0]        prod_reg  [3][3];
    logic                           m3_valid_reg, m3_inside_reg;

    assign rot_rows[0] = rot_a_reg;
    assign rot_rows[1] = rot_b_reg;
    assign rot_rows[2] = rot_c_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[j][k] = coef(rot_rows[j], k) * loc_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Sum, round to Q1.14 and saturate.
    localparam logic signed [CB+LW+1:0] ACC_RND = (44'sd1 <<< (CB + 7));
    localparam int DIR_SAT = CB + LW + 2 - (CB + 8);

    logic signed [CB+LW+1:0]    acc   [3];
    logic signed [DIR_SAT-1:0]  accsh [3];
    logic signed [frd_pkg::DIR_W-1:0] sat [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc[j]   = 44'(prod_reg[j][0]) + 44'(prod_reg[j][1]) + 44'(prod_reg[j][2])
                     + ACC_RND;
            accsh[j] = acc[j][CB+LW+1:CB+8];
            if (accsh[j] > 20'sd32767)
            begin
                sat[j] = 16'sd32767;
            end
            else if (accsh[j] < -20'sd32768)
            begin
                sat[j] = -16'sd32768;
            end
            else
            begin
                sat[j] = accsh[j][frd_pkg::DIR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg  <= last_side.valid;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_inside_reg <= last_side.in_circle;
            m2_inside_reg <= m1_inside_reg;
            m3_inside_reg <= m2_inside_reg;
            defined       <= m3_inside_reg;
            dir_x         <= m3_inside_reg ? sat[0] : '0;
            dir_y         <= m3_inside_reg ? sat[1] : '0;
            dir_z         <= m3_inside_reg ? sat[2] : '0;
        end
    end

endmodule

[verif/ray_dir_checker.sv]
`timescale 1ns / 100ps

// Watches the pixel, direction and register channels of the fisheye ray block.
// It keeps its own copy of the registers, predicts each direction, and checks
// every direction item against the oldest prediction.
module ray_dir_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [frd_pkg::PIX_W-1:0]       column,
    input  logic [frd_pkg::PIX_W-1:0]       row,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [frd_pkg::DIR_W-1:0] dir_x,
    input  logic signed [frd_pkg::DIR_W-1:0] dir_y,
    input  logic signed [frd_pkg::DIR_W-1:0] dir_z,
    input  logic                            defined,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [frd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              n_directions,
    output int                              n_inside,
    output int                              n_writes
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               in_circle;
    } ray_dir_t;

    localparam longint ATAN_TAB [28] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic [12:0] view_w, view_h, fov;
    logic [47:0] mat_a, mat_b, mat_c;
    ray_dir_t    expected_dirs[$];

    function automatic longint norm_q30(input longint p, input longint size);
        longint d;
        longint q;
        d = 2 * p - size;
        q = (((d < 0 ? -d : d) <<< 30) + size / 2) / size;
        return d < 0 ? -q : q;
    endfunction

    function automatic longint ratio_q30(input longint a, input longint rad);
        longint q;
        q = (((a < 0 ? -a : a) <<< 30) + rad / 2) / rad;
        if (q > (64'sd1 <<< 30))
            q = 64'sd1 <<< 30;
        return a < 0 ? -q : q;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] rotate_row(input logic [47:0] m,
                                                      input longint lx,
                                                      input longint ly,
                                                      input longint lz);
        longint acc;
        acc = longint'($signed(m[47:32])) * lx + longint'($signed(m[31:16])) * ly
            + longint'($signed(m[15:0])) * lz;
        acc = (acc + (64'sd1 <<< 23)) >>> 24;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return acc[15:0];
    endfunction

    function automatic ray_dir_t predict_dir(input logic [11:0] c, input logic [11:0] r);
        ray_dir_t        res;
        longint          w, h, dx, dy, u, v, rad, cos_a, sin_a, psi, x, y, z, xs, ys;
        longint          lx, ly, lz;
        longint unsigned prod;
        logic            neg_cos;
        res = '0;
        w = (view_w > 4096) ? 4096 : view_w;
        h = (view_h > 4096) ? 4096 : view_h;
        if (w == 0 || h == 0)
            return res;
        dx = 2 * longint'(c) - w;
        dy = 2 * longint'(r) - h;
        if (dx * dx * h * h + dy * dy * w * w > w * w * h * h)
            return res;
        u = norm_q30(c, w);
        v = norm_q30(r, h);
        rad = int_sqrt(longint'(u * u + v * v));
        if (rad == 0)
        begin
            cos_a = 0;
            sin_a = 0;
        end
        else
        begin
            cos_a = ratio_q30(u, rad);
            sin_a = ratio_q30(v, rad);
        end
        prod = longint'(rad) * longint'(fov) * 64'd1171271 + 64'h1_0000_0000;
        psi = longint'(prod >> 33);
        neg_cos = 1'b0;
        if (psi > 421657428)
        begin
            psi = 843314857 - psi;
            neg_cos = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = psi;
        for (int i = 0; i < 28; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end
        end
        if (neg_cos)
            x = -x;
        lx = (mul_q30(y, cos_a) + 32) >>> 6;
        ly = (mul_q30(y, sin_a) + 32) >>> 6;
        lz = (x + 32) >>> 6;
        res.x = rotate_row(mat_a, lx, ly, lz);
        res.y = rotate_row(mat_b, lx, ly, lz);
        res.z = rotate_row(mat_c, lx, ly, lz);
        res.in_circle = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ray_dir_t want;
        if (!rst_n)
        begin
            view_w = 13'd640;
            view_h = 13'd480;
            fov = 13'd2880;
            mat_a = 48'h4000_0000_0000;
            mat_b = 48'h0000_4000_0000;
            mat_c = 48'h0000_0000_4000;
            expected_dirs.delete();
            mismatches = 0;
            n_directions = 0;
            n_inside = 0;
            n_writes = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_writes++;
                case (cfg_index)
                    frd_pkg::REG_VIEW_WIDTH:    view_w = cfg_data[12:0];
                    frd_pkg::REG_VIEW_HEIGHT:   view_h = cfg_data[12:0];
                    frd_pkg::REG_FIELD_OF_VIEW: fov = cfg_data[12:0];
                    frd_pkg::REG_ROT_ROW_A:     mat_a = cfg_data;
                    frd_pkg::REG_ROT_ROW_B:     mat_b = cfg_data;
                    frd_pkg::REG_ROT_ROW_C:     mat_c = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                n_directions++;
                if (expected_dirs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("direction item with nothing expected: %0d %0d %0d def %0d",
                                 dir_x, dir_y, dir_z, defined);
                end
                else
                begin
                    want = expected_dirs.pop_front();
                    if (want.in_circle)
                        n_inside++;
                    if (dir_x !== want.x || dir_y !== want.y || dir_z !== want.z
                        || defined !== want.in_circle)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"direction mismatch: want %0d %0d %0d def %0d,",
                                      " got %0d %0d %0d def %0d"},
                                     want.x, want.y, want.z, want.in_circle,
                                     dir_x, dir_y, dir_z, defined);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_dirs.push_back(predict_dir(column, row));
        end
        pending = expected_dirs.size();
    end

endmodule

[verif/tb_fisheye_ray_direction_top.sv]
`timescale 1ns / 100ps

module tb_fisheye_ray_direction_top;

    // Index values outside the register list; writes to them must be ignored.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    // This tail covers the full pipeline depth with some margin.
    localparam int DRAIN_TAIL = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] column = '0;
    logic [11:0] row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic        defined;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    int mismatches, pending, n_directions, n_inside, n_writes;

    // When calm is set neither side inserts gaps, so the pipeline runs at full rate.
    logic calm = 1'b0;
    int   stall_left = 0;
    // Effective view size, used to aim most pixels at the visible box.
    int   cur_w = 640;
    int   cur_h = 480;

    fisheye_ray_direction_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .column    (column),
        .row       (row),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .defined   (defined),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ray_dir_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .defined      (defined),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .n_directions (n_directions),
        .n_inside     (n_inside),
        .n_writes     (n_writes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 40)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // The receiver stalls at random, holding each stall for the picked length.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Offers one pixel after a random gap and returns at the edge it is taken.
    task automatic send_pixel(input int c, input int r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        column <= c[11:0];
        row <= r[11:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == frd_pkg::REG_VIEW_WIDTH)
            cur_w = (data[12:0] > 4096) ? 4096 : int'(data[12:0]);
        if (idx == frd_pkg::REG_VIEW_HEIGHT)
            cur_h = (data[12:0] > 4096) ? 4096 : int'(data[12:0]);
    endtask

    // Holds the sender until every expected direction is back, then waits the tail.
    task automatic wait_idle(input int tail);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (tail) @(posedge clk);
    endtask

    function automatic logic [47:0] random_row();
        logic [47:0] m;
        m = {$urandom, $urandom};
        // Half the rows are small unit-like coefficients, half are raw bit patterns.
        if ($urandom_range(0, 1))
            m = {16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384)};
        return m;
    endfunction

    function automatic logic [47:0] random_size();
        case ($urandom_range(0, 7))
            0:       return 48'($urandom_range(1, 4));
            1:       return 48'd4096;
            2:       return 48'd8191;
            3:       return 48'($urandom_range(4097, 8191));
            4:       return 48'($urandom_range(1, 64));
            default: return 48'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [47:0] random_fov();
        case ($urandom_range(0, 5))
            0:       return 48'd0;
            1:       return 48'd5760;
            2:       return 48'($urandom_range(5761, 8191));
            default: return 48'($urandom_range(0, 5760));
        endcase
    endfunction

    initial
    begin
        int c, r, lim_c, lim_r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: center pixel gives the optical axis, the edge pixels
        // sit exactly on the unit circle, corners fall outside.
        send_pixel(320, 240);
        send_pixel(0, 240);
        send_pixel(640, 240);
        send_pixel(320, 0);
        send_pixel(320, 480);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(100, 200);
        wait_idle(DRAIN_TAIL);

        // Oversized view saturates to the largest size; extreme coefficients in the
        // first two rows can drive those components into saturation; the third row is zero.
        write_reg(frd_pkg::REG_VIEW_WIDTH, 48'h1FFF);
        write_reg(frd_pkg::REG_VIEW_HEIGHT, 48'hFFFF_FFFF_FFFF);
        write_reg(frd_pkg::REG_FIELD_OF_VIEW, 48'd5760);
        write_reg(frd_pkg::REG_ROT_ROW_A, 48'h7FFF_7FFF_7FFF);
        write_reg(frd_pkg::REG_ROT_ROW_B, 48'h8000_8000_8000);
        write_reg(frd_pkg::REG_ROT_ROW_C, 48'h0);
        write_reg(REG_SPARE_LO, 48'h1234_5678_9ABC);
        write_reg(REG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
        send_pixel(2048, 2048);
        send_pixel(0, 2048);
        send_pixel(4095, 2048);
        send_pixel(1, 2048);
        send_pixel(600, 1000);
        wait_idle(DRAIN_TAIL);

        // Zero width means no pixel is inside; then a two-by-two view
        // with a field of view past a half turn.
        write_reg(frd_pkg::REG_VIEW_WIDTH, 48'd0);
        send_pixel(0, 0);
        send_pixel(5, 5);
        wait_idle(DRAIN_TAIL);
        write_reg(frd_pkg::REG_VIEW_WIDTH, 48'd2);
        write_reg(frd_pkg::REG_VIEW_HEIGHT, 48'd2);
        write_reg(frd_pkg::REG_FIELD_OF_VIEW, 48'd8191);
        send_pixel(1, 1);
        send_pixel(0, 1);
        send_pixel(2, 1);
        send_pixel(1, 0);
        send_pixel(0, 0);
        wait_idle(DRAIN_TAIL);

        // Random phases, each with fresh settings. Most pixels land in the
        // visible box so that many fall inside the circle.
        for (int ph = 0; ph < 10; ph++)
        begin
            calm = (ph == 4);
            write_reg(frd_pkg::REG_VIEW_WIDTH, random_size());
            write_reg(frd_pkg::REG_VIEW_HEIGHT, random_size());
            write_reg(frd_pkg::REG_FIELD_OF_VIEW, random_fov());
            write_reg(frd_pkg::REG_ROT_ROW_A, random_row());
            write_reg(frd_pkg::REG_ROT_ROW_B, random_row());
            write_reg(frd_pkg::REG_ROT_ROW_C, random_row());
            lim_c = (cur_w > 4095) ? 4095 : cur_w;
            lim_r = (cur_h > 4095) ? 4095 : cur_h;
            for (int k = 0; k < 100; k++)
            begin
                if ($urandom_range(0, 99) < 20)
                begin
                    c = $urandom_range(0, 4095);
                    r = $urandom_range(0, 4095);
                end
                else
                begin
                    c = $urandom_range(0, lim_c);
                    r = $urandom_range(0, lim_r);
                end
                send_pixel(c, r);
                // Once per run the sender waits for the pipeline to empty.
                if (ph == 2 && k == 50)
                    wait_idle(0);
            end
            wait_idle(DRAIN_TAIL);
        end
        calm = 1'b0;

        $display("Run covered %0d pixel items, %0d inside the circle, %0d register writes.",
                 n_directions, n_inside, n_writes);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Generous bound on the whole run; reaching it means the block stopped moving.
    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[fisheye_ray_direction_top.f]
src/frd_pkg.sv
src/frd_front.sv
src/frd_divider.sv
src/frd_sqrt.sv
src/frd_cordic.sv
src/fisheye_ray_direction_top.sv
verif/ray_dir_checker.sv
verif/tb_fisheye_ray_direction_top.sv
